### rtl/core/udp_port_packet_classifier_core_assert.svh
// Assertion macros shared by the UDP port classifier core.
`ifndef UDP_PORT_PACKET_CLASSIFIER_CORE_ASSERT_SVH
`define UDP_PORT_PACKET_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UPC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define UPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/upc_pkg.sv
// Types and constants of the UDP port classifier core.
`default_nettype none

package upc_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic [5:0] queue_index;
   } req_payload_type;

   typedef struct packed {
      logic       redirect;
      logic [5:0] target_queue;
   } rsp_payload_type;

   // One parse step: a buffered request that moves into the parser this cycle.
   typedef struct packed {
      logic            fire;
      req_payload_type item;
   } step_type;

   typedef enum logic [5:0] {
      PH_ETH  = 6'b000001,
      PH_TAG  = 6'b000010,
      PH_IPV4 = 6'b000100,
      PH_IPV6 = 6'b001000,
      PH_UDP  = 6'b010000,
      PH_DONE = 6'b100000
   } phase_type;

   localparam logic [15:0] FEED_PORT_RESET = 16'd5000;
   localparam logic [15:0] TPID_CTAG       = 16'h8100;
   localparam logic [15:0] TPID_STAG       = 16'h88A8;
   localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6      = 16'h86DD;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;

   localparam logic [7:0]  ETH_TYPE_HI_OFF = 8'd12;
   localparam logic [7:0]  ETH_TYPE_LO_OFF = 8'd13;
   localparam logic [7:0]  ETH_HDR_LEN     = 8'd14;
   localparam logic [7:0]  TAG_TYPE_HI_REL = 8'd2;
   localparam logic [7:0]  TAG_TYPE_LO_REL = 8'd3;
   localparam logic [7:0]  IPV4_IHL_REL    = 8'd0;
   localparam logic [7:0]  IPV4_PROTO_REL  = 8'd9;
   localparam logic [7:0]  IPV4_MIN_END    = 8'd19;
   localparam logic [5:0]  IPV4_MIN_HLEN   = 6'd20;
   localparam logic [7:0]  IPV6_NEXT_REL   = 8'd6;
   localparam logic [7:0]  IPV6_LAST_REL   = 8'd39;
   localparam logic [7:0]  UDP_DPORT_HI    = 8'd2;
   localparam logic [7:0]  UDP_DPORT_LO    = 8'd3;
   localparam logic [7:0]  UDP_LAST_REL    = 8'd7;
   localparam logic [7:0]  OFFSET_MAX      = 8'hFF;

endpackage

`default_nettype wire

### rtl/core/upc_in_stage.sv
// Input register of the classifier: holds one request until the parser takes it.
`default_nettype none

module upc_in_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire upc_pkg::req_payload_type req_data,
   output logic                          req_stall,
   input  wire logic                     advance,
   output logic                          buf_valid,
   output upc_pkg::req_payload_type      buf_data
);

   logic                     valid_ff, valid_in;
   upc_pkg::req_payload_type data_ff;
   logic                     accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign buf_valid = valid_ff;
   assign buf_data  = data_ff;

endmodule

`default_nettype wire

### rtl/core/upc_parser.sv
// Per-byte header parser: frame state, port register and verdict logic.
`default_nettype none

`include "udp_port_packet_classifier_core_assert.svh"

module upc_parser #(
   parameter int MAX_VLAN_TAGS = 2,
   parameter int QUEUE_COUNT   = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write,
   input  wire logic [15:0]              csr_data,
   input  wire upc_pkg::step_type        step,
   output upc_pkg::rsp_payload_type      verdict
);

   logic [15:0]        feed_port_ff;
   logic [7:0]         off_ff, off_in;
   upc_pkg::phase_type phase_ff, phase_in;
   logic [15:0]        et_ff, et_in;
   logic [1:0]         tags_ff, tags_in;
   logic [7:0]         hs_ff, hs_in;
   logic [5:0]         ihl_ff, ihl_in;
   logic               pm_ff, pm_in;
   logic               rej_ff, rej_in;

   logic [7:0] b;
   logic [7:0] rel;
   logic [7:0] off_plus;
   logic       et_done;
   logic [7:0] dispatch_start;
   logic       queue_ok;

   assign b        = step.item.data_byte;
   assign rel      = off_ff - hs_ff;
   assign off_plus = off_ff + 8'd1;
   assign queue_ok = 32'(step.item.queue_index) < QUEUE_COUNT;

   always_comb begin
      phase_in       = phase_ff;
      et_in          = et_ff;
      tags_in        = tags_ff;
      hs_in          = hs_ff;
      ihl_in         = ihl_ff;
      pm_in          = pm_ff;
      rej_in         = rej_ff;
      et_done        = 1'b0;
      dispatch_start = upc_pkg::ETH_HDR_LEN;

      if (!rej_ff) begin
         unique case (phase_ff)
            upc_pkg::PH_ETH: begin
               if (off_ff == upc_pkg::ETH_TYPE_HI_OFF) begin
                  et_in = {b, 8'h00};
               end else if (off_ff == upc_pkg::ETH_TYPE_LO_OFF) begin
                  et_in   = {et_ff[15:8], b};
                  et_done = 1'b1;
               end
            end
            upc_pkg::PH_TAG: begin
               if (rel == upc_pkg::TAG_TYPE_HI_REL) begin
                  et_in = {b, 8'h00};
               end else if (rel == upc_pkg::TAG_TYPE_LO_REL) begin
                  et_in          = {et_ff[15:8], b};
                  et_done        = 1'b1;
                  dispatch_start = off_plus;
               end
            end
            upc_pkg::PH_IPV4: begin
               if (rel == upc_pkg::IPV4_IHL_REL) begin
                  ihl_in = {b[3:0], 2'b00};
                  if ({b[3:0], 2'b00} < upc_pkg::IPV4_MIN_HLEN) begin
                     rej_in = 1'b1;
                  end
               end else if (rel == upc_pkg::IPV4_PROTO_REL) begin
                  if (b != upc_pkg::PROTO_UDP) begin
                     rej_in = 1'b1;
                  end
               end else if (rel >= upc_pkg::IPV4_MIN_END &&
                            ({1'b0, rel} + 9'd1) == {3'b000, ihl_ff}) begin
                  phase_in = upc_pkg::PH_UDP;
                  hs_in    = off_plus;
               end
            end
            upc_pkg::PH_IPV6: begin
               if (rel == upc_pkg::IPV6_NEXT_REL) begin
                  if (b != upc_pkg::PROTO_UDP) begin
                     rej_in = 1'b1;
                  end
               end else if (rel == upc_pkg::IPV6_LAST_REL) begin
                  phase_in = upc_pkg::PH_UDP;
                  hs_in    = off_plus;
               end
            end
            upc_pkg::PH_UDP: begin
               if (rel == upc_pkg::UDP_DPORT_HI) begin
                  pm_in = (b == feed_port_ff[15:8]);
               end else if (rel == upc_pkg::UDP_DPORT_LO) begin
                  pm_in = pm_ff && (b == feed_port_ff[7:0]);
               end else if (rel == upc_pkg::UDP_LAST_REL) begin
                  phase_in = upc_pkg::PH_DONE;
               end
            end
            upc_pkg::PH_DONE: begin
            end
            default: begin
            end
         endcase

         // type field complete: another tag, an IP header, or reject
         if (et_done) begin
            if (et_in == upc_pkg::TPID_CTAG || et_in == upc_pkg::TPID_STAG) begin
               if (32'(tags_ff) < MAX_VLAN_TAGS) begin
                  tags_in  = tags_ff + 2'd1;
                  phase_in = upc_pkg::PH_TAG;
                  hs_in    = dispatch_start;
               end else begin
                  rej_in = 1'b1;
               end
            end else if (et_in == upc_pkg::ETYPE_IPV4) begin
               phase_in = upc_pkg::PH_IPV4;
               hs_in    = dispatch_start;
            end else if (et_in == upc_pkg::ETYPE_IPV6) begin
               phase_in = upc_pkg::PH_IPV6;
               hs_in    = dispatch_start;
            end else begin
               rej_in = 1'b1;
            end
         end
      end

      off_in = (off_ff == upc_pkg::OFFSET_MAX) ? off_ff : off_plus;

      verdict.redirect     = !rej_in && (phase_in == upc_pkg::PH_DONE) && pm_in && queue_ok;
      verdict.target_queue = verdict.redirect ? step.item.queue_index : 6'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_port_ff <= upc_pkg::FEED_PORT_RESET;
      end else if (csr_write) begin
         feed_port_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= 8'd0;
         phase_ff <= upc_pkg::PH_ETH;
         et_ff    <= 16'd0;
         tags_ff  <= 2'd0;
         hs_ff    <= 8'd0;
         ihl_ff   <= 6'd0;
         pm_ff    <= 1'b0;
         rej_ff   <= 1'b0;
      end else if (step.fire) begin
         if (step.item.last_byte) begin
            off_ff   <= 8'd0;
            phase_ff <= upc_pkg::PH_ETH;
            et_ff    <= 16'd0;
            tags_ff  <= 2'd0;
            hs_ff    <= 8'd0;
            ihl_ff   <= 6'd0;
            pm_ff    <= 1'b0;
            rej_ff   <= 1'b0;
         end else begin
            off_ff   <= off_in;
            phase_ff <= phase_in;
            et_ff    <= et_in;
            tags_ff  <= tags_in;
            hs_ff    <= hs_in;
            ihl_ff   <= ihl_in;
            pm_ff    <= pm_in;
            rej_ff   <= rej_in;
         end
      end
   end

   `UPC_ASSERT_IMPL(a_tag_bound, clock, reset, 1'b1, 32'(tags_ff) <= MAX_VLAN_TAGS,
                    "tag count over limit")
   `UPC_ASSERT_NEXT(a_frame_clear, clock, reset, step.fire && step.item.last_byte,
                    off_ff == 8'd0 && phase_ff == upc_pkg::PH_ETH && !rej_ff,
                    "frame state not cleared after last byte")

endmodule

`default_nettype wire

### rtl/core/upc_rsp_stage.sv
// Result register: holds one verdict until the receiver takes it.
`default_nettype none

module upc_rsp_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire upc_pkg::rsp_payload_type load_data,
   output logic                          rsp_valid,
   output upc_pkg::rsp_payload_type      rsp_data,
   input  wire logic                     rsp_stall
);

   logic                     valid_ff, valid_in;
   upc_pkg::rsp_payload_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### rtl/core/udp_port_packet_classifier_core.sv
// Top level of the UDP port classifier core.
// Usage:
//   req channel: one frame byte per request with its last-byte mark and queue
//     number (req_valid / req_stall / req_data).
//   rsp channel: one verdict per frame, sent for the last byte: redirect and
//     target queue, target queue zero on pass (rsp_valid / rsp_stall / rsp_data).
//   csr channel: write of the UDP destination port to redirect; always ready,
//     write only while no frame byte is in flight.
// Path: input register, then parse logic, then the result register that drives rsp.
// Throughput: one byte per cycle unless a last byte waits on a held verdict;
//   each byte's parse step is constant logic between the two registers.
// Reset: clears the frame parser to the Ethernet header, empties both
//   registers, and loads port 5000.
// Stall: with a verdict waiting under rsp_stall, non-last bytes keep flowing;
//   a buffered last byte waits and req_stall rises until the verdict is taken.
`default_nettype none

`include "udp_port_packet_classifier_core_assert.svh"

module udp_port_packet_classifier_core #(
   parameter int MAX_VLAN_TAGS = 2,
   parameter int QUEUE_COUNT   = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire upc_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output upc_pkg::rsp_payload_type      rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [15:0]              csr_data
);

   logic                     buf_valid;
   upc_pkg::req_payload_type buf_data;
   logic                     advance;
   upc_pkg::step_type        step;
   upc_pkg::rsp_payload_type verdict;

   assign csr_ready = 1'b1;

   // a last byte needs a free result register
   assign advance = buf_valid && !(buf_data.last_byte && rsp_valid && rsp_stall);

   assign step.fire = advance;
   assign step.item = buf_data;

   upc_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .advance   (advance),
      .buf_valid (buf_valid),
      .buf_data  (buf_data)
   );

   upc_parser #(
      .MAX_VLAN_TAGS (MAX_VLAN_TAGS),
      .QUEUE_COUNT   (QUEUE_COUNT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .step      (step),
      .verdict   (verdict)
   );

   upc_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && buf_data.last_byte),
      .load_data (verdict),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   `UPC_ASSERT_IMPL(a_pass_zero_queue, clock, reset, rsp_valid && !rsp_data.redirect, rsp_data.target_queue == 6'd0, "pass verdict with nonzero queue")
   `UPC_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, buf_valid && buf_data.last_byte && rsp_valid && rsp_stall, "request stalled without a blocked verdict")
   `UPC_ASSERT_NEXT(a_verdict_loaded, clock, reset, advance && buf_data.last_byte, rsp_valid, "verdict lost after last byte")

endmodule

`default_nettype wire

### tb/udp_port_packet_classifier_core_test.sv
// Self-checking testbench for the UDP port classifier core: frames in, verdicts out.
`timescale 1ns / 100ps

module udp_port_packet_classifier_core_test;

   localparam int          MAX_VLAN_TAGS = 2;
   localparam int          QUEUE_COUNT   = 64;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned DRAIN_CYCLES  = 8;

   localparam logic [15:0] CTAG  = upc_pkg::TPID_CTAG;
   localparam logic [15:0] STAG  = upc_pkg::TPID_STAG;
   localparam logic [15:0] IPV4  = upc_pkg::ETYPE_IPV4;
   localparam logic [15:0] IPV6  = upc_pkg::ETYPE_IPV6;
   localparam logic [7:0]  UDP   = upc_pkg::PROTO_UDP;
   localparam logic [15:0] PORT0 = upc_pkg::FEED_PORT_RESET;

   // One frame as the stimulus sees it; a typed row carries its verdict.
   typedef struct packed {
      logic [1:0]  tag_cnt;
      logic [15:0] tag_tpid;
      logic [15:0] net_type;
      logic [7:0]  ver_ihl;
      logic [7:0]  l4_proto;
      logic [15:0] dst_port;
      logic [7:0]  payload_len;
      logic [8:0]  cut_len;
      logic [5:0]  queue;
      logic        typed;
      logic        want_redirect;
   } frame_recipe_type;

   typedef struct packed {
      upc_pkg::req_payload_type item;
      logic                     typed;
      upc_pkg::rsp_payload_type typed_verdict;
   } byte_entry_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   upc_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   upc_pkg::rsp_payload_type rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [15:0]              csr_data;

   // Classifier shadow state
   logic [15:0]        feed_port_q;
   logic [7:0]         at_offset;
   upc_pkg::phase_type at_phase;
   logic [15:0]        ether_word;
   logic [1:0]         tags_seen;
   logic [7:0]         hdr_base;
   logic [5:0]         ip_hlen;
   logic               port_hit;
   logic               dropped;

   byte_entry_type           byte_backlog[$];
   upc_pkg::rsp_payload_type verdict_fifo[$];
   frame_recipe_type         directed_frames[$];
   byte_entry_type           in_flight;
   upc_pkg::rsp_payload_type predicted;
   upc_pkg::rsp_payload_type want;
   bit                       got_verdict;
   bit                       req_taken;
   bit                       idling_on;
   int unsigned              req_gap;
   int unsigned              stall_left;
   int unsigned              cycle_count;
   int unsigned              mismatches;
   int unsigned              bytes_queued;
   int unsigned              frames_queued;
   int unsigned              verdicts_checked;
   int unsigned              redirects_seen;

   udp_port_packet_classifier_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_frame();
      at_offset  = '0;
      at_phase   = upc_pkg::PH_ETH;
      ether_word = '0;
      tags_seen  = '0;
      hdr_base   = '0;
      ip_hlen    = '0;
      port_hit   = 1'b0;
      dropped    = 1'b0;
   endfunction

   function automatic void take_ether_type(logic [7:0] next_start);
      if (ether_word == CTAG || ether_word == STAG) begin
         if (int'(tags_seen) < MAX_VLAN_TAGS) begin
            tags_seen = tags_seen + 2'd1;
            at_phase  = upc_pkg::PH_TAG;
            hdr_base  = next_start;
         end else begin
            dropped = 1'b1;
         end
      end else if (ether_word == IPV4) begin
         at_phase = upc_pkg::PH_IPV4;
         hdr_base = next_start;
      end else if (ether_word == IPV6) begin
         at_phase = upc_pkg::PH_IPV6;
         hdr_base = next_start;
      end else begin
         dropped = 1'b1;
      end
   endfunction

   function automatic void parse_frame_byte(logic [7:0] b, logic [7:0] off);
      logic [7:0] rel;
      rel = off - hdr_base;
      case (at_phase)
         upc_pkg::PH_ETH: begin
            if (off == 8'd12) begin
               ether_word = {b, 8'h00};
            end else if (off == 8'd13) begin
               ether_word[7:0] = b;
               take_ether_type(8'd14);
            end
         end
         upc_pkg::PH_TAG: begin
            if (rel == 8'd2) begin
               ether_word = {b, 8'h00};
            end else if (rel == 8'd3) begin
               ether_word[7:0] = b;
               take_ether_type(off + 8'd1);
            end
         end
         upc_pkg::PH_IPV4: begin
            if (rel == 8'd0) begin
               ip_hlen = {b[3:0], 2'b00};
               if (ip_hlen < 6'd20) dropped = 1'b1;
            end else if (rel == 8'd9) begin
               if (b != UDP) dropped = 1'b1;
            end else if (rel >= 8'd19 && int'(rel) + 1 == int'(ip_hlen)) begin
               at_phase = upc_pkg::PH_UDP;
               hdr_base = off + 8'd1;
            end
         end
         upc_pkg::PH_IPV6: begin
            if (rel == 8'd6) begin
               if (b != UDP) dropped = 1'b1;
            end else if (rel == 8'd39) begin
               at_phase = upc_pkg::PH_UDP;
               hdr_base = off + 8'd1;
            end
         end
         upc_pkg::PH_UDP: begin
            if (rel == 8'd2) begin
               port_hit = (b == feed_port_q[15:8]);
            end else if (rel == 8'd3) begin
               port_hit = port_hit && (b == feed_port_q[7:0]);
            end else if (rel == 8'd7) begin
               at_phase = upc_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   // Advances the shadow parser by one byte; returns 1 when the byte ends a frame.
   function automatic bit classify_byte(input upc_pkg::req_payload_type r,
                                        output upc_pkg::rsp_payload_type v);
      v = '0;
      if (!dropped) parse_frame_byte(r.data_byte, at_offset);
      if (at_offset != upc_pkg::OFFSET_MAX) at_offset = at_offset + 8'd1;
      if (!r.last_byte) return 1'b0;
      v.redirect = !dropped && at_phase == upc_pkg::PH_DONE && port_hit &&
                   int'(r.queue_index) < QUEUE_COUNT;
      v.target_queue = v.redirect ? r.queue_index : 6'd0;
      clear_frame();
      return 1'b1;
   endfunction

   function automatic frame_recipe_type recipe(int unsigned tags, logic [15:0] tpid,
                                               logic [15:0] net_type, logic [7:0] ver_ihl,
                                               logic [7:0] proto, logic [15:0] dport,
                                               int unsigned pay, int unsigned cut,
                                               int unsigned queue, bit typed, bit want);
      frame_recipe_type r;
      r.tag_cnt       = 2'(tags);
      r.tag_tpid      = tpid;
      r.net_type      = net_type;
      r.ver_ihl       = ver_ihl;
      r.l4_proto      = proto;
      r.dst_port      = dport;
      r.payload_len   = 8'(pay);
      r.cut_len       = 9'(cut);
      r.queue         = 6'(queue);
      r.typed         = typed;
      r.want_redirect = want;
      return r;
   endfunction

   function automatic frame_recipe_type random_recipe(logic [15:0] port);
      frame_recipe_type r;
      logic [3:0]       ihl;
      r.tag_cnt  = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 2)) : 2'd0;
      r.tag_tpid = $urandom_range(0, 1) ? CTAG : STAG;
      r.net_type = $urandom_range(0, 1) ? IPV4 : IPV6;
      ihl        = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
      r.ver_ihl  = {4'h4, ihl};
      r.l4_proto = UDP;
      case ($urandom_range(0, 7))
         0: r.dst_port = 16'($urandom);
         1: r.dst_port = port ^ (16'd1 << $urandom_range(0, 15));
         default: r.dst_port = port;
      endcase
      r.payload_len   = 8'($urandom_range(0, 24));
      r.cut_len       = '0;
      r.queue         = 6'($urandom);
      r.typed         = 1'b0;
      r.want_redirect = 1'b0;
      // one recipe in five gets one header field or its length disturbed
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 5))
            0: r.tag_cnt = 2'd3;
            1: r.net_type = 16'($urandom);
            2: r.ver_ihl = 8'($urandom);
            3: r.l4_proto = 8'($urandom);
            4: r.cut_len = 9'($urandom_range(1, 70));
            default: r.ver_ihl[3:0] = 4'($urandom_range(0, 4));
         endcase
      end
      return r;
   endfunction

   task automatic queue_frame(frame_recipe_type f);
      logic [7:0]     fb[$];
      int unsigned    hlen;
      byte_entry_type e;
      repeat (12) fb.push_back(8'($urandom));
      for (int i = 0; i < int'(f.tag_cnt); i++) begin
         fb.push_back(f.tag_tpid[15:8]);
         fb.push_back(f.tag_tpid[7:0]);
         fb.push_back(8'($urandom));
         fb.push_back(8'($urandom));
      end
      fb.push_back(f.net_type[15:8]);
      fb.push_back(f.net_type[7:0]);
      if (f.net_type == IPV6) begin
         for (int i = 0; i < 40; i++) fb.push_back(i == 6 ? f.l4_proto : 8'($urandom));
      end else begin
         hlen = 4 * int'(f.ver_ihl[3:0]);
         if (hlen < 20) hlen = 20;
         for (int i = 0; i < int'(hlen); i++) begin
            fb.push_back(i == 0 ? f.ver_ihl : (i == 9 ? f.l4_proto : 8'($urandom)));
         end
      end
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom));
      fb.push_back(f.dst_port[15:8]);
      fb.push_back(f.dst_port[7:0]);
      repeat (4) fb.push_back(8'($urandom));
      repeat (int'(f.payload_len)) fb.push_back(8'($urandom));
      if (f.cut_len != '0) begin
         while (fb.size() > int'(f.cut_len)) void'(fb.pop_back());
         while (fb.size() < int'(f.cut_len)) fb.push_back(8'($urandom));
      end
      foreach (fb[i]) begin
         e.item.data_byte             = fb[i];
         e.item.last_byte             = (i == fb.size() - 1);
         e.item.queue_index           = f.queue;
         e.typed                      = f.typed && e.item.last_byte;
         e.typed_verdict.redirect     = f.want_redirect;
         e.typed_verdict.target_queue = f.want_redirect ? f.queue : 6'd0;
         byte_backlog.push_back(e);
      end
      bytes_queued  += fb.size();
      frames_queued += 1;
   endtask

   task automatic queue_noise_frame(int unsigned len);
      byte_entry_type e;
      for (int unsigned i = 0; i < len; i++) begin
         e.item.data_byte   = 8'($urandom);
         e.item.last_byte   = (i == len - 1);
         e.item.queue_index = 6'($urandom);
         e.typed            = 1'b0;
         e.typed_verdict    = '0;
         byte_backlog.push_back(e);
      end
      bytes_queued  += len;
      frames_queued += 1;
   endtask

   task automatic await_idle();
      while (byte_backlog.size() != 0 || req_valid || verdict_fifo.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_feed_port(logic [15:0] port);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= port;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(logic [15:0] port, bit with_idling);
      int unsigned first_byte;
      write_feed_port(port);
      idling_on  = with_idling;
      first_byte = bytes_queued;
      while (bytes_queued - first_byte < 40) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_noise_frame($urandom_range(1, 64));
         end else begin
            queue_frame(random_recipe(port));
         end
      end
      await_idle();
   endtask

   task automatic flag_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // request driver: next byte goes out once the current one is taken and any idle gap has run out
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (byte_backlog.size() > 0) begin
            in_flight = byte_backlog.pop_front();
            req_valid <= 1'b1;
            req_data  <= in_flight.item;
            if (idling_on && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (idling_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 6);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (csr_valid && csr_ready) feed_port_q = csr_data;
         if (req_valid && !req_stall) begin
            req_taken   = 1'b1;
            got_verdict = classify_byte(in_flight.item, predicted);
            if (got_verdict) begin
               verdict_fifo.push_back(in_flight.typed ? in_flight.typed_verdict : predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_fifo.size() == 0) begin
               flag_mismatch("verdict with no frame pending");
            end else begin
               want = verdict_fifo.pop_front();
               if (rsp_data.redirect !== want.redirect)
                  flag_mismatch($sformatf("redirect %b, expected %b",
                                          rsp_data.redirect, want.redirect));
               if (rsp_data.target_queue !== want.target_queue)
                  flag_mismatch($sformatf("target_queue %0d, expected %0d",
                                          rsp_data.target_queue, want.target_queue));
               verdicts_checked++;
               if (want.redirect) redirects_seen++;
            end
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, verdict_fifo.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data  = '0;
      idling_on = 1'b1;
      feed_port_q = PORT0;
      clear_frame();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tags tpid type ver_ihl proto dport payload cut queue typed redirect
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, UDP, PORT0, 0, 0, 63, 1, 1));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, UDP, 16'h1389, 4, 0, 5, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h4F, UDP, PORT0, 3, 0, 0, 0, 0));
      // version nibble is ignored
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h65, UDP, PORT0, 2, 0, 17, 0, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h44, UDP, PORT0, 0, 0, 9, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h40, UDP, PORT0, 0, 0, 9, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, 8'h06, PORT0, 0, 0, 9, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, 8'hFF, PORT0, 0, 0, 9, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV6, 8'h60, UDP, PORT0, 1, 0, 42, 0, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV6, 8'h60, 8'h00, PORT0, 0, 0, 42, 1, 0));
      directed_frames.push_back(recipe(1, CTAG, IPV4, 8'h45, UDP, PORT0, 6, 0, 1, 0, 0));
      directed_frames.push_back(recipe(2, STAG, IPV6, 8'h60, UDP, PORT0, 0, 0, 62, 0, 0));
      directed_frames.push_back(recipe(2, CTAG, IPV4, 8'h46, UDP, PORT0, 0, 0, 3, 0, 0));
      // one tag too many
      directed_frames.push_back(recipe(3, CTAG, IPV4, 8'h45, UDP, PORT0, 0, 0, 3, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, 16'h0806, 8'h45, UDP, PORT0, 0, 0, 7, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                       0, 0, 7, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, 16'h0000, 8'h00, 8'h00, 16'h0000,
                                       0, 0, 7, 1, 0));
      // truncated: inside the type field, one byte short of a full UDP header, lone byte
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, UDP, PORT0, 0, 13, 7, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, UDP, PORT0, 0, 41, 7, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, UDP, PORT0, 0, 1, 7, 1, 0));
      // long enough that the offset counter saturates
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, UDP, PORT0, 0, 300, 11, 0, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, UDP, 16'h13FF, 0, 0, 2, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, UDP, 16'hFF88, 0, 0, 2, 1, 0));
      directed_frames.push_back(recipe(0, CTAG, IPV4, 8'h45, UDP, PORT0, 0, 0, 0, 1, 1));
      foreach (directed_frames[i]) queue_frame(directed_frames[i]);
      await_idle();

      run_phase(16'h0000, 1'b1);
      run_phase(16'hFFFF, 1'b1);
      run_phase(16'($urandom), 1'b0);
      run_phase(16'($urandom), 1'b1);
      run_phase(PORT0, 1'b0);

      $display("Ran %0d frames (%0d bytes) over six port settings, extremes included;",
               frames_queued, bytes_queued);
      $display("checked %0d verdicts, %0d of them redirects, %0d mismatches.",
               verdicts_checked, redirects_seen, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
